// ----- rtl/vertex_project_clip_rect_core_macros.svh -----
// assertion macros for the vertex projection core
// used by the top level, needs clk and rst_n in scope
`ifndef VERTEX_PROJECT_CLIP_RECT_CORE_MACROS_SVH
`define VERTEX_PROJECT_CLIP_RECT_CORE_MACROS_SVH

// checked only out of reset
`define VPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define VPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/vpc_pkg.sv -----
// shared types, constants and saturation helper for the vertex projection core
// no dependencies
`timescale 1ns / 1ps

package vpc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SAT_W = 72;

  localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
  localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
  localparam logic [2:0] REG_VIEW_WIDTH  = 3'd2;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd3;

  localparam logic [11:0] VIEW_LEFT_RST   = 12'd0;
  localparam logic [11:0] VIEW_TOP_RST    = 12'd0;
  localparam logic [12:0] VIEW_WIDTH_RST  = 13'd640;
  localparam logic [12:0] VIEW_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] width;
    logic [12:0] height;
  } viewport_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] res;
    if (v > $signed(SAT_W'(32'h7FFF_FFFF))) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -$signed(SAT_W'(33'h0_8000_0000))) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/vpc_div.sv -----
// pipelined fixed point divider, one quotient bit per stage
// depends on vpc_pkg
`timescale 1ns / 1ps

module vpc_div #(
  parameter int FRAC_BITS = vpc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo
);

  localparam int NQ = 32 + FRAC_BITS;

  logic [31:0]    rem_r  [NQ+1];
  logic [NQ-1:0]  bits_r [NQ+1];
  logic [NQ-1:0]  q_r    [NQ+1];
  logic [31:0]    den_r  [NQ+1];
  logic           neg_r  [NQ+1];
  logic           dz_r   [NQ+1];
  logic           apos_r [NQ+1];
  logic           aneg_r [NQ+1];

  logic [31:0]    rem_nxt [NQ];
  logic           qb_nxt  [NQ];
  logic [33:0]    diff    [NQ];
  logic [32:0]    shifted [NQ];
  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign num_mag = num[31] ? (~num + 32'd1) : num;
  assign den_mag = den[31] ? (~den + 32'd1) : den;

  always_comb begin
    for (int s = 0; s < NQ; s++) begin
      shifted[s] = {rem_r[s], bits_r[s][NQ-1]};
      diff[s]    = {1'b0, shifted[s]} - {2'b00, den_r[s]};
      qb_nxt[s]  = ~diff[s][33];
      rem_nxt[s] = diff[s][33] ? shifted[s][31:0] : diff[s][31:0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    bits_r[0] <= {num_mag, {FRAC_BITS{1'b0}}};
    q_r[0]    <= '0;
    den_r[0]  <= den_mag;
    neg_r[0]  <= num[31] ^ den[31];
    dz_r[0]   <= (den == 32'sd0);
    apos_r[0] <= (num > 32'sd0);
    aneg_r[0] <= num[31];
    for (int s = 0; s < NQ; s++) begin
      rem_r[s+1]  <= rem_nxt[s];
      bits_r[s+1] <= {bits_r[s][NQ-2:0], 1'b0};
      q_r[s+1]    <= {q_r[s][NQ-2:0], qb_nxt[s]};
      den_r[s+1]  <= den_r[s];
      neg_r[s+1]  <= neg_r[s];
      dz_r[s+1]   <= dz_r[s];
      apos_r[s+1] <= apos_r[s];
      aneg_r[s+1] <= aneg_r[s];
    end
  end

  // sign, saturation and the divide by zero cases
  always_comb begin
    if (dz_r[NQ]) begin
      quo_nxt = apos_r[NQ] ? 32'sh7FFF_FFFF : (aneg_r[NQ] ? 32'sh8000_0000 : 32'sd0);
    end else if (neg_r[NQ]) begin
      quo_nxt = vpc_pkg::sat32(-$signed(vpc_pkg::SAT_W'(q_r[NQ])));
    end else begin
      quo_nxt = vpc_pkg::sat32($signed(vpc_pkg::SAT_W'(q_r[NQ])));
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

// ----- rtl/vpc_viewport.sv -----
// viewport mapping stages: extent, half offsets, pixel scaling, saturation
// depends on vpc_pkg
`timescale 1ns / 1ps

module vpc_viewport #(
  parameter int FRAC_BITS = vpc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic                in_vis,
  input  logic signed [31:0]  sx,
  input  logic signed [31:0]  sy,
  input  logic signed [31:0]  sz,
  input  logic signed [31:0]  qx,
  input  logic signed [31:0]  qy,
  input  vpc_pkg::viewport_t  vp,
  output logic                out_valid,
  output logic                out_visible,
  output logic signed [31:0]  out_rect_x,
  output logic signed [31:0]  out_rect_y,
  output logic signed [31:0]  out_rect_w,
  output logic signed [31:0]  out_rect_h,
  output logic signed [31:0]  out_depth
);

  localparam int SW = vpc_pkg::SAT_W;

  logic h_vld_r, h_vis_r, i_vld_r, i_vis_r, j_vld_r, j_vis_r, k_vld_r, k_vis_r;
  logic signed [31:0] h_sx_r, h_sy_r, h_sz_r, h_rx_r, h_ry_r;
  logic signed [33:0] i_dx_r, i_dy_r;
  logic signed [45:0] i_wp_r, i_hp_r;
  logic signed [31:0] i_sz_r;
  logic signed [47:0] j_xp_r, j_yp_r;
  logic signed [31:0] j_rw_r, j_rh_r, j_sz_r;
  logic signed [31:0] k_x_r, k_y_r, k_w_r, k_h_r, k_d_r;
  logic signed [13:0] vw, vh;
  logic signed [SW-1:0] base_x, base_y;

  assign vw = $signed({1'b0, vp.width});
  assign vh = $signed({1'b0, vp.height});
  assign base_x = ($signed({{(SW-12){1'b0}}, vp.left}) <<< FRAC_BITS)
                + ($signed({{(SW-13){1'b0}}, vp.width}) <<< (FRAC_BITS - 1));
  assign base_y = ($signed({{(SW-12){1'b0}}, vp.top}) <<< FRAC_BITS)
                + ($signed({{(SW-13){1'b0}}, vp.height}) <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
    end else begin
      h_vld_r <= in_vld;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    // extent before scaling to the viewport
    h_vis_r <= in_vis;
    h_sx_r  <= sx;
    h_sy_r  <= sy;
    h_sz_r  <= sz;
    h_rx_r  <= vpc_pkg::sat32(SW'(qx) - SW'(sx));
    h_ry_r  <= vpc_pkg::sat32(SW'(qy) - SW'(sy));
    // centre offsets and extent products
    i_vis_r <= h_vis_r;
    i_dx_r  <= 34'(h_sx_r) - 34'(h_rx_r >>> 1);
    i_dy_r  <= 34'(h_sy_r) + 34'(h_ry_r >>> 1);
    i_wp_r  <= h_rx_r * vw;
    i_hp_r  <= h_ry_r * vh;
    i_sz_r  <= h_sz_r;
    // position products
    j_vis_r <= i_vis_r;
    j_xp_r  <= i_dx_r * vw;
    j_yp_r  <= i_dy_r * vh;
    j_rw_r  <= vpc_pkg::sat32(SW'(i_wp_r >>> 1));
    j_rh_r  <= vpc_pkg::sat32(SW'(i_hp_r >>> 1));
    j_sz_r  <= i_sz_r;
    // result, zeroed for a rejected point
    k_vis_r <= j_vis_r;
    if (j_vis_r) begin
      k_x_r <= vpc_pkg::sat32(base_x + SW'(j_xp_r >>> 1));
      k_y_r <= vpc_pkg::sat32(base_y - SW'(j_yp_r >>> 1));
      k_w_r <= j_rw_r;
      k_h_r <= j_rh_r;
      k_d_r <= j_sz_r;
    end else begin
      k_x_r <= '0;
      k_y_r <= '0;
      k_w_r <= '0;
      k_h_r <= '0;
      k_d_r <= '0;
    end
  end

  assign out_valid   = k_vld_r;
  assign out_visible = k_vis_r;
  assign out_rect_x  = k_x_r;
  assign out_rect_y  = k_y_r;
  assign out_rect_w  = k_w_r;
  assign out_rect_h  = k_h_r;
  assign out_depth   = k_d_r;

endmodule

// ----- rtl/vertex_project_clip_rect_core.sv -----
// top level of the vertex projection core: matrices, transforms, clip, dividers
// depends on vpc_pkg, vpc_div, vpc_viewport and the macros header
`timescale 1ns / 1ps
`include "vertex_project_clip_rect_core_macros.svh"

// Fully pipelined: one item may be started in every cycle and busy is low
// whenever reset is released. A point item gives exactly one result, a strobe
// on out_valid for one cycle. From its transfer a point passes through six
// transform stages, FRAC_BITS + 34 divider stages (FRAC_BITS is 16 at the
// default Q16.16) and four viewport stages. The dividers set most of the
// latency, since they resolve one quotient bit per stage. A matrix load
// gives no result. Loads stay in order with points: a load issued after a
// point never affects that point, and a point issued after a load always sees
// it. The result side cannot stall, so results must be taken when shown.
// Configuration writes are always ready and take effect at once; change them
// only with no point in flight.
module vertex_project_clip_rect_core #(
  parameter int FRAC_BITS = vpc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic               in_mat_sel,
  input  logic [3:0]         in_mat_index,
  input  logic signed [31:0] in_mat_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_radius,
  // result strobe
  output logic               out_valid,
  output logic               out_visible,
  output logic signed [31:0] out_rect_x,
  output logic signed [31:0] out_rect_y,
  output logic signed [31:0] out_rect_w,
  output logic signed [31:0] out_rect_h,
  output logic signed [31:0] out_depth,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  localparam int SW = vpc_pkg::SAT_W;
  // divider: input stage, one stage per quotient bit, output stage
  localparam int DIV_LAT = FRAC_BITS + 34;

  logic in_xfer;
  assign busy    = ~rst_n;
  assign in_xfer = start & ~busy;
  assign cfg_ready = 1'b1;

  // viewport registers
  vpc_pkg::viewport_t vp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r.left   <= vpc_pkg::VIEW_LEFT_RST;
      vp_r.top    <= vpc_pkg::VIEW_TOP_RST;
      vp_r.width  <= vpc_pkg::VIEW_WIDTH_RST;
      vp_r.height <= vpc_pkg::VIEW_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vpc_pkg::REG_VIEW_LEFT:   vp_r.left   <= cfg_data[11:0];
        vpc_pkg::REG_VIEW_TOP:    vp_r.top    <= cfg_data[11:0];
        vpc_pkg::REG_VIEW_WIDTH:  vp_r.width  <= cfg_data;
        vpc_pkg::REG_VIEW_HEIGHT: vp_r.height <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // matrix storage, column-major (index = column*4 + row)
  logic signed [31:0] view_m_r [16];
  logic signed [31:0] proj_m_r [16];

  // stage a: captured command
  logic               a_pt_r, a_ldp_r;
  logic [3:0]         a_idx_r;
  logic signed [31:0] a_val_r, a_x_r, a_y_r, a_z_r, a_rad_r;
  // stage b: view products
  logic               b_pt_r, b_ldp_r;
  logic [3:0]         b_idx_r;
  logic signed [31:0] b_val_r, b_rad_r;
  logic signed [63:0] b_prd_r [3][3];
  logic signed [31:0] b_tr_r  [3];
  // stage c: view space point
  logic               c_pt_r, c_ldp_r;
  logic [3:0]         c_idx_r;
  logic signed [31:0] c_val_r, c_rad_r;
  logic signed [31:0] c_vp_r [3];
  // stage d: radius shifted point
  logic               d_pt_r, d_ldp_r;
  logic [3:0]         d_idx_r;
  logic signed [31:0] d_val_r, d_xs_r, d_ys_r;
  logic signed [31:0] d_vp_r [3];
  // stage e: projection products, centre (all rows) and shifted (rows x, y, w)
  logic               e_pt_r;
  logic signed [63:0] e_pc_r [4][3];
  logic signed [63:0] e_ps_r [3][2];
  logic signed [31:0] e_tr_r [4];
  // stage f: clip space
  logic               f_pt_r;
  logic signed [31:0] f_pp_r [4];
  logic signed [31:0] f_rp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pt_r  <= 1'b0;
      a_ldp_r <= 1'b0;
      b_pt_r  <= 1'b0;
      b_ldp_r <= 1'b0;
      c_pt_r  <= 1'b0;
      c_ldp_r <= 1'b0;
      d_pt_r  <= 1'b0;
      d_ldp_r <= 1'b0;
      e_pt_r  <= 1'b0;
      f_pt_r  <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        view_m_r[i] <= '0;
        proj_m_r[i] <= '0;
      end
    end else begin
      a_pt_r  <= in_xfer & in_op;
      a_ldp_r <= in_xfer & ~in_op & in_mat_sel;
      b_pt_r  <= a_pt_r;
      b_ldp_r <= a_ldp_r;
      c_pt_r  <= b_pt_r;
      c_ldp_r <= b_ldp_r;
      d_pt_r  <= c_pt_r;
      d_ldp_r <= c_ldp_r;
      e_pt_r  <= d_pt_r;
      f_pt_r  <= e_pt_r;
      // view words are used right after capture, so they land on transfer
      if (in_xfer && !in_op && !in_mat_sel) begin
        view_m_r[in_mat_index] <= in_mat_value;
      end
      // projection words land where the projection is read
      if (d_ldp_r) begin
        proj_m_r[d_idx_r] <= d_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r <= in_mat_index;
    a_val_r <= in_mat_value;
    a_x_r   <= in_point_x;
    a_y_r   <= in_point_y;
    a_z_r   <= in_point_z;
    a_rad_r <= in_radius;

    b_idx_r <= a_idx_r;
    b_val_r <= a_val_r;
    b_rad_r <= a_rad_r;
    for (int r = 0; r < 3; r++) begin
      b_prd_r[r][0] <= view_m_r[4'(r)] * a_x_r;
      b_prd_r[r][1] <= view_m_r[4'(4 + r)] * a_y_r;
      b_prd_r[r][2] <= view_m_r[4'(8 + r)] * a_z_r;
      b_tr_r[r]     <= view_m_r[4'(12 + r)];
    end

    c_idx_r <= b_idx_r;
    c_val_r <= b_val_r;
    c_rad_r <= b_rad_r;
    for (int r = 0; r < 3; r++) begin
      c_vp_r[r] <= vpc_pkg::sat32(SW'(b_tr_r[r]) + SW'(b_prd_r[r][0] >>> FRAC_BITS)
                                  + SW'(b_prd_r[r][1] >>> FRAC_BITS)
                                  + SW'(b_prd_r[r][2] >>> FRAC_BITS));
    end

    d_idx_r <= c_idx_r;
    d_val_r <= c_val_r;
    d_vp_r  <= c_vp_r;
    d_xs_r  <= vpc_pkg::sat32(SW'(c_vp_r[0]) + SW'(c_rad_r));
    d_ys_r  <= vpc_pkg::sat32(SW'(c_vp_r[1]) + SW'(c_rad_r));

    for (int r = 0; r < 4; r++) begin
      e_pc_r[r][0] <= proj_m_r[4'(r)] * d_vp_r[0];
      e_pc_r[r][1] <= proj_m_r[4'(4 + r)] * d_vp_r[1];
      e_pc_r[r][2] <= proj_m_r[4'(8 + r)] * d_vp_r[2];
      e_tr_r[r]    <= proj_m_r[4'(12 + r)];
    end
    for (int k = 0; k < 3; k++) begin
      // shifted rows x, y and w
      e_ps_r[k][0] <= proj_m_r[4'((k == 2) ? 3 : k)] * d_xs_r;
      e_ps_r[k][1] <= proj_m_r[4'(4 + ((k == 2) ? 3 : k))] * d_ys_r;
    end

    for (int r = 0; r < 4; r++) begin
      f_pp_r[r] <= vpc_pkg::sat32(SW'(e_tr_r[r]) + SW'(e_pc_r[r][0] >>> FRAC_BITS)
                                  + SW'(e_pc_r[r][1] >>> FRAC_BITS)
                                  + SW'(e_pc_r[r][2] >>> FRAC_BITS));
    end
    for (int k = 0; k < 3; k++) begin
      f_rp_r[k] <= vpc_pkg::sat32(SW'(e_tr_r[(k == 2) ? 3 : k])
                                  + SW'(e_ps_r[k][0] >>> FRAC_BITS)
                                  + SW'(e_ps_r[k][1] >>> FRAC_BITS)
                                  + SW'(e_pc_r[(k == 2) ? 3 : k][2] >>> FRAC_BITS));
    end
  end

  // clip test against the w of the centre
  logic signed [33:0] cx, cy, cz, cw;
  logic clip_vis;
  assign cx = 34'(f_pp_r[0]);
  assign cy = 34'(f_pp_r[1]);
  assign cz = 34'(f_pp_r[2]);
  assign cw = 34'(f_pp_r[3]);
  assign clip_vis = !(cx < -cw || cx > cw || cy < -cw || cy > cw || cz < -cw);

  // valid and visible ride alongside the dividers
  logic dl_pt_r  [DIV_LAT];
  logic dl_vis_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_pt_r[i] <= 1'b0;
      end
    end else begin
      dl_pt_r[0] <= f_pt_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_pt_r[i] <= dl_pt_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_vis_r[0] <= clip_vis;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_vis_r[i] <= dl_vis_r[i-1];
    end
  end

  logic signed [31:0] q_sx, q_sy, q_sz, q_rx, q_ry;

  vpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_sx (
    .clk(clk), .num(f_pp_r[0]), .den(f_pp_r[3]), .quo(q_sx));
  vpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_sy (
    .clk(clk), .num(f_pp_r[1]), .den(f_pp_r[3]), .quo(q_sy));
  vpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_sz (
    .clk(clk), .num(f_pp_r[2]), .den(f_pp_r[3]), .quo(q_sz));
  vpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_rx (
    .clk(clk), .num(f_rp_r[0]), .den(f_rp_r[2]), .quo(q_rx));
  vpc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ry (
    .clk(clk), .num(f_rp_r[1]), .den(f_rp_r[2]), .quo(q_ry));

  vpc_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (dl_pt_r[DIV_LAT-1]),
    .in_vis      (dl_vis_r[DIV_LAT-1]),
    .sx          (q_sx),
    .sy          (q_sy),
    .sz          (q_sz),
    .qx          (q_rx),
    .qy          (q_ry),
    .vp          (vp_r),
    .out_valid   (out_valid),
    .out_visible (out_visible),
    .out_rect_x  (out_rect_x),
    .out_rect_y  (out_rect_y),
    .out_rect_w  (out_rect_w),
    .out_rect_h  (out_rect_h),
    .out_depth   (out_depth)
  );

  // all result fields zero
  logic out_zero;
  assign out_zero = (out_rect_x == 32'sd0) && (out_rect_y == 32'sd0)
                 && (out_rect_w == 32'sd0) && (out_rect_h == 32'sd0)
                 && (out_depth == 32'sd0);

  // no result strobe right after a reset cycle
  `VPC_ASSERT_RST(a_rst_flush, !rst_n |=> !out_valid, "result strobe after reset")
  // rejected point carries an all zero payload
  `VPC_ASSERT(a_reject_zero, out_valid && !out_visible |-> out_zero, "rejected nonzero payload")
  // a projection load reaching stage d is written into the matrix
  `VPC_ASSERT(a_proj_write, d_ldp_r |=> proj_m_r[$past(d_idx_r)] == $past(d_val_r), "proj word lost")

endmodule
